/* src/ess_pkg.sv */
package ess_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	// Counts that may reach the depth itself, such as the length and the search bound.
	localparam int CNT_W       = ADDR_W + 1;

	// Field widths of the channels and the register.
	localparam int KEY_W = 32;
	localparam int IDX_W = 10;
	localparam int LEN_W = 11;

	// Each memory word holds the present mark above the key.
	localparam int WORD_W = KEY_W + 1;

	// Operation codes of an input item.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

endpackage

/* src/ess_item_if.sv */
interface ess_item_if import ess_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic [IDX_W-1:0]        entry_index;
	logic signed [KEY_W-1:0] key_value;
	logic                    entry_present;

	modport source (output valid, output operation, output entry_index, output key_value,
		output entry_present, input ready);
	modport sink (input valid, input operation, input entry_index, input key_value,
		input entry_present, output ready);
endinterface

/* src/ess_result_if.sv */
interface ess_result_if import ess_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [IDX_W-1:0] found_index;

	modport source (output valid, output found, output found_index, input ready);
	modport sink (input valid, input found, input found_index, output ready);
endinterface

/* src/ess_ram.sv */
module ess_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/exponential_search_sorted_table_core.sv */
// Sorted key table with exponential search.
//
// Items arrive on req: a write item (operation write) stores key_value and
// entry_present at entry_index; an index at or above the table depth is dropped.
// A search item looks for key_value among the first table_length entries and
// gives one result on rsp: found and found_index, or zero and zero.
// table_length must be written through cfg_we/cfg_wdata only while the block
// is idle, which the block itself does not enforce; values above the depth are
// treated as the depth. Keys and present marks live in one memory with
// registered read data, and every probe reads one entry: the read is issued in
// one cycle and decided in the next, which also issues the following read. The
// probes of a search are entry zero, up to log2(depth) bound doublings and up to
// log2(depth) binary steps. One item is worked on at a time; req stays ready
// while a result waits on rsp, and a search that finishes while rsp is stalled
// waits until the result register frees.
// After reset the block clears every present mark, one entry a cycle; req is
// not ready during that pass, register writes are taken.
module exponential_search_sorted_table_core import ess_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	ess_item_if.sink         req,
	ess_result_if.source     rsp
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ZERO,
		ST_EXP,
		ST_BIN,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [LEN_W-1:0]        table_length_q;
	logic [ADDR_W-1:0]       clr_q;
	logic signed [KEY_W-1:0] target_q;
	logic [CNT_W-1:0]        len_q;
	logic [CNT_W-1:0]        bound_q;
	logic [ADDR_W-1:0]       lo_q;
	logic [ADDR_W-1:0]       hi_q;
	logic [ADDR_W-1:0]       mid_q;
	logic                    res_found_q;
	logic [ADDR_W-1:0]       res_idx_q;
	logic                    out_valid_q;
	logic                    out_found_q;
	logic [IDX_W-1:0]        out_index_q;

	logic                    req_fire;
	logic                    out_load;
	logic                    idx_ok;
	logic [CNT_W-1:0]        len_clamp;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [WORD_W-1:0]       ram_wdata;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [WORD_W-1:0]       ram_rdata;
	logic                    rd_present;
	logic signed [KEY_W-1:0] rd_key;
	logic                    key_lt;
	logic                    key_eq;
	logic [CNT_W-1:0]        bound_dbl;
	logic [CNT_W-1:0]        bin_bound;
	logic [CNT_W-1:0]        bound_n;
	logic                    enter_bin;
	logic                    bin_cont;
	logic                    go_exp;
	logic                    go_done;
	logic                    done_found;
	logic [ADDR_W-1:0]       done_idx;
	logic [ADDR_W-1:0]       lo_n;
	logic [ADDR_W-1:0]       hi_n;
	logic [ADDR_W-1:0]       mid_n;

	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign idx_ok    = 32'(req.entry_index) < 32'(TABLE_DEPTH);
	assign len_clamp = (32'(table_length_q) > 32'(TABLE_DEPTH)) ?
		CNT_W'(TABLE_DEPTH) : CNT_W'(table_length_q);

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_found_q;
	assign rsp.found_index = out_index_q;

	// The length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
		end else if (cfg_we) begin
			table_length_q <= cfg_wdata;
		end
	end

	// Write port: the clearing pass after reset, then write items.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = req_fire && (req.operation == OP_WRITE) && idx_ok;
			ram_waddr = ADDR_W'(req.entry_index);
			ram_wdata = {req.entry_present, req.key_value};
		end
	end

	ess_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_present = ram_rdata[KEY_W];
	assign rd_key     = $signed(ram_rdata[KEY_W-1:0]);
	assign key_lt     = rd_key < target_q;
	assign key_eq     = rd_key == target_q;
	assign bound_dbl  = {bound_q[CNT_W-2:0], 1'b0};

	// Decide on the entry just read and pick the next probe address.
	always_comb begin
		enter_bin  = 1'b0;
		bin_cont   = 1'b0;
		go_exp     = 1'b0;
		go_done    = 1'b0;
		done_found = 1'b0;
		done_idx   = '0;
		bin_bound  = bound_q;
		bound_n    = bound_q;
		lo_n       = lo_q;
		hi_n       = hi_q;
		ram_raddr  = '0;
		case (state_q)
			ST_ZERO: begin
				if (!rd_present) begin
					go_done = 1'b1;
				end else if (key_eq) begin
					go_done    = 1'b1;
					done_found = 1'b1;
				end else if (len_q > CNT_W'(1)) begin
					go_exp  = 1'b1;
					bound_n = CNT_W'(1);
				end else begin
					enter_bin = 1'b1;
					bin_bound = CNT_W'(1);
				end
			end
			ST_EXP: begin
				if (!rd_present) begin
					go_done = 1'b1;
				end else if (!key_lt) begin
					enter_bin = 1'b1;
					bin_bound = bound_q;
				end else if (bound_dbl < len_q) begin
					go_exp  = 1'b1;
					bound_n = bound_dbl;
				end else begin
					enter_bin = 1'b1;
					bin_bound = bound_dbl;
				end
			end
			ST_BIN: begin
				if (!rd_present) begin
					go_done = 1'b1;
				end else if (key_eq) begin
					go_done    = 1'b1;
					done_found = 1'b1;
					done_idx   = mid_q;
				end else if (key_lt) begin
					// The key at the middle is below the target: move the low end up.
					if (mid_q == hi_q) begin
						go_done = 1'b1;
					end else begin
						bin_cont = 1'b1;
						lo_n     = mid_q + ADDR_W'(1);
					end
				end else begin
					// The key at the middle is above the target: move the high end down.
					if (mid_q == lo_q) begin
						go_done = 1'b1;
					end else begin
						bin_cont = 1'b1;
						hi_n     = mid_q - ADDR_W'(1);
					end
				end
			end
			default: begin
			end
		endcase

		// Range of the binary search once the bound is settled.
		if (enter_bin) begin
			lo_n = ADDR_W'(bin_bound >> 1);
			hi_n = (bin_bound < len_q) ? ADDR_W'(bin_bound) : ADDR_W'(len_q - CNT_W'(1));
		end
		mid_n = lo_n + ((hi_n - lo_n) >> 1);

		if (go_exp) begin
			ram_raddr = ADDR_W'(bound_n);
		end else if (enter_bin || bin_cont) begin
			ram_raddr = mid_n;
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire && (req.operation == OP_SEARCH)) begin
						target_q <= req.key_value;
						len_q    <= len_clamp;
						if (len_clamp == '0) begin
							res_found_q <= 1'b0;
							res_idx_q   <= '0;
							state_q     <= ST_DONE;
						end else begin
							state_q <= ST_ZERO;
						end
					end
				end
				ST_ZERO, ST_EXP, ST_BIN: begin
					if (go_done) begin
						res_found_q <= done_found;
						res_idx_q   <= done_idx;
						state_q     <= ST_DONE;
					end else if (go_exp) begin
						bound_q <= bound_n;
						state_q <= ST_EXP;
					end else begin
						lo_q    <= lo_n;
						hi_q    <= hi_n;
						mid_q   <= mid_n;
						state_q <= ST_BIN;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_found_q <= res_found_q;
						out_index_q <= IDX_W'(res_idx_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/ess_checker.sv */
module ess_checker import ess_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             req_operation,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic             rsp_found,
	input logic [IDX_W-1:0] rsp_found_index
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_found_index))
		else $error("result payload changed while stalled");

	// A miss always reports index zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_found_index == '0)
		else $error("miss with nonzero index");

	// A write item accepted with no result pending creates no result.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_operation == OP_WRITE) && !rsp_valid |=> !rsp_valid)
		else $error("write item produced a result");

	// Once a search is taken, no further item is taken in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_operation == OP_SEARCH) |=> !req_ready)
		else $error("item accepted while a search is running");

endmodule

bind exponential_search_sorted_table_core ess_checker u_ess_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_operation  (req.operation),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_found      (rsp.found),
	.rsp_found_index(rsp.found_index)
);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
	import ess_pkg::*;

	// Run limits and the pause that lets a finished item settle inside the block.
	localparam int     RUN_LIMIT     = 400000;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     PHASE_ITEMS   = 65;
	localparam longint KEY_MIN       = -(64'sd1 <<< 31);
	localparam longint KEY_MAX       = (64'sd1 <<< 31) - 1;

	// One expected search answer.
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] slot;
	} lookup_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [LEN_W-1:0] cfg_wdata = '0;

	ess_item_if   req ();
	ess_result_if rsp ();

	exponential_search_sorted_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	// Shadow copy of the table and its length, updated as items are accepted.
	logic signed [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
	logic                    shadow_marks [TABLE_DEPTH];
	logic [LEN_W-1:0]        shadow_len = '0;

	lookup_t pending_lookups [$];

	int cycles = 0;
	int errors = 0;
	int writes_sent = 0;
	int searches_sent = 0;
	int hits_seen = 0;
	int lengths_used = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	// A noisy write is undone by the next write item.
	int                      repair_idx = -1;
	logic signed [KEY_W-1:0] repair_key;

	always #1 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_lookups.size());
			$display("FAIL exponential_search_sorted_table_core");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	// Exponential search over the shadow table, then binary search in the last span.
	function automatic lookup_t lookup_key(input logic signed [KEY_W-1:0] target);
		lookup_t answer;
		int      span;
		int      bound;
		int      lo;
		int      hi;
		int      mid;
		answer = '0;
		span = (shadow_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_len);
		if (span < 1 || !shadow_marks[0])
			return answer;
		if (shadow_keys[0] == target) begin
			answer.found = 1'b1;
			return answer;
		end
		bound = 1;
		while (bound < span) begin
			if (!shadow_marks[bound])
				return answer;
			if (shadow_keys[bound] >= target)
				break;
			bound *= 2;
		end
		lo = bound / 2;
		hi = (bound < span) ? bound : span - 1;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (!shadow_marks[mid])
				return answer;
			if (shadow_keys[mid] == target) begin
				answer.found = 1'b1;
				answer.slot  = IDX_W'(mid);
				return answer;
			end
			if (shadow_keys[mid] > target)
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return answer;
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_between(input longint lo, input longint hi);
		longint unsigned draw;
		longint unsigned range_n;
		draw    = {$urandom(), $urandom()};
		range_n = hi - lo + 1;
		return KEY_W'(lo + longint'(draw % range_n));
	endfunction

	// Sends one item and records its effect once it is taken. Valid stays high on
	// return; the caller sends again or lowers it in the same step.
	task automatic send_item(input logic op, input int idx, input logic signed [KEY_W-1:0] key,
		input logic present);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid         <= 1'b1;
		req.operation     <= op;
		req.entry_index   <= IDX_W'(idx);
		req.key_value     <= key;
		req.entry_present <= present;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (op == OP_WRITE) begin
			shadow_keys[idx]  = key;
			shadow_marks[idx] = present;
			writes_sent++;
		end else begin
			pending_lookups.push_back(lookup_key(key));
			searches_sent++;
		end
	endtask

	// Stops sending and waits until every answer is back and the block has settled.
	task automatic wait_idle();
		req.valid <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(input int len);
		cfg_we    <= 1'b1;
		cfg_wdata <= LEN_W'(len);
		@(posedge clk);
		cfg_we     <= 1'b0;
		shadow_len = LEN_W'(len);
		lengths_used++;
	endtask

	// Result side: random stall bursts while idling is on.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp.ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rsp.ready  <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest expected answer.
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_lookups.size() == 0) begin
				report_mismatch($sformatf("unexpected result found=%0b index=%0d",
					rsp.found, rsp.found_index));
			end else begin
				want = pending_lookups.pop_front();
				if (rsp.found !== want.found)
					report_mismatch($sformatf("found %0b, expected %0b", rsp.found, want.found));
				if (rsp.found_index !== want.slot)
					report_mismatch($sformatf("found_index %0d, expected %0d",
						rsp.found_index, want.slot));
				if (want.found)
					hits_seen++;
			end
		end
	end

	// A zero length never finds anything.
	task automatic test_empty_table();
		set_length(0);
		send_item(OP_SEARCH, 0, 0, 1'b0);
		send_item(OP_SEARCH, 1023, 32'sh8000_0000, 1'b1);
		wait_idle();
	endtask

	// Eight ascending keys spanning the full signed range; lengths 8 and 1.
	task automatic test_small_table();
		logic signed [KEY_W-1:0] ladder [8];
		ladder = '{32'sh8000_0000, -1000, -5, 0, 7, 100, 5000, 32'sh7fff_ffff};
		foreach (ladder[i])
			send_item(OP_WRITE, i, ladder[i], 1'b1);
		wait_idle();
		set_length(8);
		send_item(OP_SEARCH, 0, ladder[0], 1'b0);
		send_item(OP_SEARCH, 0, ladder[7], 1'b0);
		send_item(OP_SEARCH, 0, ladder[4], 1'b0);
		send_item(OP_SEARCH, 0, 6, 1'b0);
		send_item(OP_SEARCH, 0, ladder[5], 1'b0);
		wait_idle();
		set_length(1);
		send_item(OP_SEARCH, 0, ladder[0], 1'b0);
		send_item(OP_SEARCH, 0, 0, 1'b0);
		wait_idle();
		set_length(8);
		wait_idle();
	endtask

	// Empty slots at entry zero, at a bound and at a binary midpoint, then an
	// out-of-order key that the search walks past.
	task automatic test_empty_slots();
		send_item(OP_WRITE, 0, 32'sh8000_0000, 1'b0);
		send_item(OP_SEARCH, 0, 0, 1'b0);
		send_item(OP_WRITE, 0, 32'sh8000_0000, 1'b1);
		send_item(OP_WRITE, 2, -5, 1'b0);
		send_item(OP_SEARCH, 0, 5000, 1'b0);
		send_item(OP_WRITE, 2, -5, 1'b1);
		send_item(OP_WRITE, 5, 100, 1'b0);
		send_item(OP_SEARCH, 0, 5000, 1'b0);
		send_item(OP_WRITE, 5, 100, 1'b1);
		send_item(OP_WRITE, 3, 200, 1'b1);
		send_item(OP_SEARCH, 0, 200, 1'b0);
		send_item(OP_WRITE, 3, 0, 1'b1);
		wait_idle();
	endtask

	// Fill every slot with strictly ascending keys.
	task automatic test_fill_table();
		longint k;
		k = KEY_MIN + $urandom_range(0, 1000);
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			send_item(OP_WRITE, i, KEY_W'(k), 1'b1);
			k += $urandom_range(1, 4000000);
		end
		wait_idle();
	endtask

	// Mostly searches for stored keys and near misses; writes keep the order
	// except for an occasional noisy one that the next write repairs.
	task automatic random_item(input int span);
		int                      i;
		longint                  lo;
		longint                  hi;
		logic signed [KEY_W-1:0] k;
		int                      pick;
		pick = $urandom_range(0, 99);
		if (pick < 72) begin
			pick = $urandom_range(0, 99);
			if (span > 0 && pick < 60)
				k = shadow_keys[$urandom_range(0, span - 1)];
			else if (span > 1 && pick < 82)
				k = shadow_keys[$urandom_range(0, span - 2)] + 1;
			else if (pick < 86)
				k = pick[0] ? 32'sh7fff_ffff : 32'sh8000_0000;
			else
				k = $urandom;
			send_item(OP_SEARCH, $urandom_range(0, TABLE_DEPTH - 1), k, 1'($urandom));
		end else if (repair_idx >= 0) begin
			send_item(OP_WRITE, repair_idx, repair_key, 1'b1);
			repair_idx = -1;
		end else begin
			if (span > 0 && $urandom_range(0, 4) != 0)
				i = $urandom_range(0, span - 1);
			else
				i = $urandom_range(0, TABLE_DEPTH - 1);
			if ($urandom_range(0, 6) == 0) begin
				repair_idx = i;
				repair_key = shadow_keys[i];
				if ($urandom_range(0, 1) == 1)
					send_item(OP_WRITE, i, shadow_keys[i], 1'b0);
				else
					send_item(OP_WRITE, i, $urandom, 1'b1);
			end else begin
				lo = (i == 0) ? KEY_MIN : longint'(shadow_keys[i - 1]) + 1;
				hi = (i == TABLE_DEPTH - 1) ? KEY_MAX : longint'(shadow_keys[i + 1]) - 1;
				send_item(OP_WRITE, i, pick_between(lo, hi), 1'b1);
			end
		end
	endtask

	// Random traffic under a series of lengths, extremes included; the last
	// phase runs without idling on either side.
	task automatic test_random_lengths();
		int lengths [$];
		int span;
		lengths = {1024, 2, 2047, 1, 3, $urandom_range(4, 1023), 1025, 0,
			$urandom_range(4, 64), $urandom_range(65, 1023), 1024};
		foreach (lengths[p]) begin
			if (p == lengths.size() - 1)
				idle_on = 1'b0;
			wait_idle();
			set_length(lengths[p]);
			span = (lengths[p] > TABLE_DEPTH) ? TABLE_DEPTH : lengths[p];
			repeat (PHASE_ITEMS) random_item(span);
		end
		wait_idle();
	endtask

	// Reset once, then the tests in turn and the verdict.
	initial begin
		req.valid         = 1'b0;
		req.operation     = OP_WRITE;
		req.entry_index   = '0;
		req.key_value     = '0;
		req.entry_present = 1'b0;
		// Every slot starts empty, as the block does after reset.
		foreach (shadow_marks[i])
			shadow_marks[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_small_table();
		test_empty_slots();
		test_fill_table();
		test_random_lengths();

		if (pending_lookups.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_lookups.size()));
		$display("covered %0d writes and %0d searches (%0d found) over %0d length settings,",
			writes_sent, searches_sent, hits_seen, lengths_used);
		$display("including empty, one-entry, full and oversized tables and empty-slot probes");
		if (errors == 0) begin
			$display("PASS exponential_search_sorted_table_core");
		end else begin
			$display("FAIL exponential_search_sorted_table_core");
		end
		$finish;
	end

endmodule
